// ===== hw/rtl/atx_power_button_sequencer_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the power-button sequencer
// Clocked implication checks used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ATX_POWER_BUTTON_SEQUENCER_MACROS_SVH
`define ATX_POWER_BUTTON_SEQUENCER_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define ABPS_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is held.
`define ABPS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== hw/rtl/abps_pkg.sv =====
// ----------------------------------------------------------------------------
// abps_pkg
// Types and constants shared by the power-button sequencer modules.
// ----------------------------------------------------------------------------
package abps_pkg;

    localparam int unsigned TICK_W = 16;

    // Configuration register indexes.
    localparam logic CFG_SHORT_PRESS = 1'b0;
    localparam logic CFG_LONG_PRESS  = 1'b1;

    localparam logic [TICK_W-1:0] SHORT_PRESS_RESET = 16'd100;
    localparam logic [TICK_W-1:0] LONG_PRESS_RESET  = 16'd6000;
    localparam logic [TICK_W-1:0] TICK_MAX          = 16'hFFFF;

    // Item kinds.
    localparam logic ACT_TICK    = 1'b0;
    localparam logic ACT_COMMAND = 1'b1;

    // Remote command codes.
    localparam logic [1:0] OP_NOP   = 2'd0;
    localparam logic [1:0] OP_ON    = 2'd1;
    localparam logic [1:0] OP_OFF   = 2'd2;
    localparam logic [1:0] OP_RESET = 2'd3;

    // Power event codes.
    localparam logic [1:0] EV_NONE = 2'd0;
    localparam logic [1:0] EV_ON   = 2'd1;
    localparam logic [1:0] EV_OFF  = 2'd2;

    // Reported machine state codes.
    localparam logic [2:0] MS_DOWN        = 3'd0;
    localparam logic [2:0] MS_NORMAL      = 3'd1;
    localparam logic [2:0] MS_WAIT_CHECK  = 3'd2;
    localparam logic [2:0] MS_SHORT_POWER = 3'd3;
    localparam logic [2:0] MS_LONG_POWER  = 3'd4;
    localparam logic [2:0] MS_RESET_PRESS = 3'd5;

    typedef enum logic [5:0] {
        ST_DOWN        = 6'b000001,
        ST_NORMAL      = 6'b000010,
        ST_WAIT_CHECK  = 6'b000100,
        ST_SHORT_POWER = 6'b001000,
        ST_LONG_POWER  = 6'b010000,
        ST_RESET_PRESS = 6'b100000
    } seq_state_t;

    typedef struct packed {
        logic       action;
        logic [1:0] command_op;
        logic       power_good;
    } item_t;

    typedef struct packed {
        logic       power_switch_pressed;
        logic       reset_switch_pressed;
        logic [1:0] power_event;
        logic       led_on;
        logic       command_taken;
        logic [2:0] machine_state;
    } result_t;

    function automatic logic [2:0] state_code(input seq_state_t st);
        logic [2:0] code;
        case (st)
            ST_DOWN:        code = MS_DOWN;
            ST_NORMAL:      code = MS_NORMAL;
            ST_WAIT_CHECK:  code = MS_WAIT_CHECK;
            ST_SHORT_POWER: code = MS_SHORT_POWER;
            ST_LONG_POWER:  code = MS_LONG_POWER;
            ST_RESET_PRESS: code = MS_RESET_PRESS;
            default:        code = MS_DOWN;
        endcase
        return code;
    endfunction

endpackage

// ===== hw/rtl/abps_core.sv =====
// ----------------------------------------------------------------------------
// abps_core
// Sequencer state, press counter and configuration registers, with the
// next-state logic for one command or tick transaction.
// ----------------------------------------------------------------------------
module abps_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic                              cfg_addr,
    input  logic [abps_pkg::TICK_W-1:0]       cfg_wdata,
    input  logic                              advance,
    input  abps_pkg::item_t                   item,
    output abps_pkg::result_t                 result
);

    abps_pkg::seq_state_t            state_reg, state_next;
    logic [abps_pkg::TICK_W-1:0]     press_reg, press_next;
    logic [abps_pkg::TICK_W-1:0]     press_inc;
    logic [abps_pkg::TICK_W-1:0]     short_reg, long_reg;
    logic                            last_pg_reg, last_pg_next;
    logic                            pwr_low_reg, pwr_low_next;
    logic                            rst_low_reg, rst_low_next;
    logic                            led_reg, led_next;
    logic [1:0]                      event_code;
    logic                            taken;

    always_comb begin
        state_next   = state_reg;
        press_next   = press_reg;
        last_pg_next = last_pg_reg;
        pwr_low_next = pwr_low_reg;
        rst_low_next = rst_low_reg;
        led_next     = led_reg;
        event_code   = abps_pkg::EV_NONE;
        taken        = 1'b0;
        press_inc    = (press_reg == abps_pkg::TICK_MAX) ? press_reg
                                                         : press_reg + 1'b1;

        if (item.action == abps_pkg::ACT_COMMAND) begin
            case (item.command_op)
                abps_pkg::OP_ON: begin
                    if (state_reg == abps_pkg::ST_DOWN) begin
                        pwr_low_next = 1'b1;
                        press_next   = '0;
                        state_next   = abps_pkg::ST_SHORT_POWER;
                        taken        = 1'b1;
                    end
                end
                abps_pkg::OP_OFF: begin
                    if (state_reg == abps_pkg::ST_NORMAL) begin
                        pwr_low_next = 1'b1;
                        press_next   = '0;
                        state_next   = abps_pkg::ST_LONG_POWER;
                        taken        = 1'b1;
                    end
                end
                abps_pkg::OP_RESET: begin
                    if (state_reg == abps_pkg::ST_NORMAL) begin
                        rst_low_next = 1'b1;
                        press_next   = '0;
                        state_next   = abps_pkg::ST_RESET_PRESS;
                        taken        = 1'b1;
                    end
                end
                default: begin
                    taken = 1'b0;
                end
            endcase
        end else begin
            // The power-level change is seen before the state step.
            if (item.power_good != last_pg_reg) begin
                led_next     = ~last_pg_reg;
                event_code   = last_pg_reg ? abps_pkg::EV_OFF : abps_pkg::EV_ON;
                last_pg_next = item.power_good;
            end
            press_next = press_inc;
            case (state_reg)
                abps_pkg::ST_SHORT_POWER: begin
                    if (press_inc >= short_reg) begin
                        state_next   = abps_pkg::ST_WAIT_CHECK;
                        pwr_low_next = 1'b0;
                    end
                end
                abps_pkg::ST_LONG_POWER: begin
                    if ((press_inc >= long_reg) || !item.power_good) begin
                        state_next   = abps_pkg::ST_WAIT_CHECK;
                        pwr_low_next = 1'b0;
                    end
                end
                abps_pkg::ST_RESET_PRESS: begin
                    if (press_inc >= short_reg) begin
                        state_next   = abps_pkg::ST_WAIT_CHECK;
                        rst_low_next = 1'b0;
                    end
                end
                default: begin
                    state_next = item.power_good ? abps_pkg::ST_NORMAL
                                                 : abps_pkg::ST_DOWN;
                end
            endcase
        end
    end

    always_comb begin
        result.power_switch_pressed = pwr_low_next;
        result.reset_switch_pressed = rst_low_next;
        result.power_event          = event_code;
        result.led_on               = led_next;
        result.command_taken        = taken;
        result.machine_state        = abps_pkg::state_code(state_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= abps_pkg::ST_DOWN;
            press_reg   <= '0;
            last_pg_reg <= 1'b0;
            pwr_low_reg <= 1'b0;
            rst_low_reg <= 1'b0;
            led_reg     <= 1'b0;
        end else if (advance) begin
            state_reg   <= state_next;
            press_reg   <= press_next;
            last_pg_reg <= last_pg_next;
            pwr_low_reg <= pwr_low_next;
            rst_low_reg <= rst_low_next;
            led_reg     <= led_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            short_reg <= abps_pkg::SHORT_PRESS_RESET;
            long_reg  <= abps_pkg::LONG_PRESS_RESET;
        end else if (cfg_wr_en) begin
            if (cfg_addr == abps_pkg::CFG_SHORT_PRESS) begin
                short_reg <= cfg_wdata;
            end else begin
                long_reg <= cfg_wdata;
            end
        end
    end

endmodule

// ===== hw/rtl/atx_power_button_sequencer.sv =====
// ----------------------------------------------------------------------------
// atx_power_button_sequencer
// Power-button sequencer: drives the power and reset switch lines from
// remote commands and tracks host power from one-millisecond ticks.
// ----------------------------------------------------------------------------
// Usage:
//   The s_ channel carries one transaction per command or tick. With
//   s_action high it is a remote command (s_command_op); with s_action low
//   it is a one-millisecond tick carrying the sensed s_power_good level.
//   Every input transaction yields exactly one m_ transaction holding the
//   switch line levels, a power event, the LED level, whether a command
//   started a press, and the machine state after the transaction.
//   After the edge that accepts the input, the transaction sits in the input
//   register; when it advances, the state update and the result register
//   load together, which raises m_valid.
//   Throughput is one transaction per cycle unless m_ready stalls; the only
//   loop is the core's registers, which update in the same cycle as read.
//   The user writes the short and long press lengths (cfg_wr_en, cfg_addr,
//   cfg_wdata) only while the block is idle; the block does not enforce it.
//   Reset (aresetn low, synchronous) puts the machine down, releases both
//   lines, turns the LED off and restores the default press lengths.
//   When m_ready is low a result is held in the output register while one
//   more transaction waits in the input register; s_ready then drops.
// ----------------------------------------------------------------------------
module atx_power_button_sequencer (
    input  logic                        aclk,
    input  logic                        aresetn,
    // Configuration write port.
    input  logic                        cfg_wr_en,
    input  logic                        cfg_addr,
    input  logic [abps_pkg::TICK_W-1:0] cfg_wdata,
    // Input transactions.
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_action,
    input  logic [1:0]                  s_command_op,
    input  logic                        s_power_good,
    // Result transactions.
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_power_switch_pressed,
    output logic                        m_reset_switch_pressed,
    output logic [1:0]                  m_power_event,
    output logic                        m_led_on,
    output logic                        m_command_taken,
    output logic [2:0]                  m_machine_state
);

    logic              in_valid_reg;
    abps_pkg::item_t   in_item_reg;
    logic              out_valid_reg;
    abps_pkg::result_t out_result_reg;
    abps_pkg::result_t core_result;
    logic              advance;

    // The held item moves on when the output register is free or draining.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg.action     <= s_action;
            in_item_reg.command_op <= s_command_op;
            in_item_reg.power_good <= s_power_good;
        end
    end

    abps_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .advance   (advance),
        .item      (in_item_reg),
        .result    (core_result)
    );

    // Result register: loaded whenever the core commits a transaction.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_result_reg <= core_result;
        end
    end

    assign m_valid                = out_valid_reg;
    assign m_power_switch_pressed = out_result_reg.power_switch_pressed;
    assign m_reset_switch_pressed = out_result_reg.reset_switch_pressed;
    assign m_power_event          = out_result_reg.power_event;
    assign m_led_on               = out_result_reg.led_on;
    assign m_command_taken        = out_result_reg.command_taken;
    assign m_machine_state        = out_result_reg.machine_state;

endmodule

// ===== hw/rtl/abps_checker.sv =====
// ----------------------------------------------------------------------------
// abps_checker
// Port-level checks on the power-button sequencer, bound to the top level.
// ----------------------------------------------------------------------------
`include "atx_power_button_sequencer_macros.svh"

module abps_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic                        m_power_switch_pressed,
    input logic                        m_reset_switch_pressed,
    input logic [1:0]                  m_power_event,
    input logic                        m_led_on,
    input logic                        m_command_taken,
    input logic [2:0]                  m_machine_state
);

    // A stalled result transaction keeps its machine state and power event.
    `ABPS_ASSERT_NEXT(a_stall_hold, aclk, aresetn, m_valid && !m_ready,
        m_valid && $stable(m_machine_state) && $stable(m_power_event))

    // Power and reset switches are never pressed at the same time.
    `ABPS_ASSERT_IMPL(a_one_press, aclk, aresetn, m_valid,
        !(m_power_switch_pressed && m_reset_switch_pressed))

    // A command never reports a power event.
    `ABPS_ASSERT_IMPL(a_cmd_no_event, aclk, aresetn, m_valid && m_command_taken,
        m_power_event == abps_pkg::EV_NONE)

    // A powered-on event lights the LED.
    `ABPS_ASSERT_IMPL(a_led_on_event, aclk, aresetn,
        m_valid && (m_power_event == abps_pkg::EV_ON), m_led_on)

    // Idle states never hold a switch line low.
    `ABPS_ASSERT_IMPL(a_idle_released, aclk, aresetn,
        m_valid && ((m_machine_state == abps_pkg::MS_DOWN) ||
                    (m_machine_state == abps_pkg::MS_NORMAL) ||
                    (m_machine_state == abps_pkg::MS_WAIT_CHECK)),
        !m_power_switch_pressed && !m_reset_switch_pressed)

endmodule

bind atx_power_button_sequencer abps_checker u_abps_checker (.*);

// ===== sim/tb_atx_power_button_sequencer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the power-button sequencer
// Drives command and tick transactions with random idling on both channels,
// predicts every result with an independent model of the press state
// machine, and checks each result field against the prediction.
// ----------------------------------------------------------------------------

class button_press_scoreboard;

    logic [abps_pkg::TICK_W-1:0] short_len;
    logic [abps_pkg::TICK_W-1:0] long_len;
    logic [2:0]                  seq_code;
    logic [abps_pkg::TICK_W-1:0] press_count;
    logic                        pg_seen;
    logic                        pwr_line;
    logic                        rst_line;
    logic                        led_level;
    abps_pkg::result_t           predicted[$];
    int                          failures;

    function void clear();
        short_len   = abps_pkg::SHORT_PRESS_RESET;
        long_len    = abps_pkg::LONG_PRESS_RESET;
        seq_code    = abps_pkg::MS_DOWN;
        press_count = '0;
        pg_seen     = 1'b0;
        pwr_line    = 1'b0;
        rst_line    = 1'b0;
        led_level   = 1'b0;
        predicted.delete();
        failures    = 0;
    endfunction

    function void write_reg(logic idx, logic [abps_pkg::TICK_W-1:0] val);
        if (idx == abps_pkg::CFG_SHORT_PRESS) begin
            short_len = val;
        end else begin
            long_len = val;
        end
    endfunction

    function int pending();
        return predicted.size();
    endfunction

    // Advances the predicted machine by one accepted transaction.
    function void note_item(logic act, logic [1:0] op, logic pg);
        abps_pkg::result_t r;
        logic [1:0]        ev;
        logic              taken;
        ev    = abps_pkg::EV_NONE;
        taken = 1'b0;
        if (act == abps_pkg::ACT_COMMAND) begin
            if (op == abps_pkg::OP_ON && seq_code == abps_pkg::MS_DOWN) begin
                pwr_line = 1'b1;
                seq_code = abps_pkg::MS_SHORT_POWER;
                taken    = 1'b1;
            end else if (op == abps_pkg::OP_OFF && seq_code == abps_pkg::MS_NORMAL) begin
                pwr_line = 1'b1;
                seq_code = abps_pkg::MS_LONG_POWER;
                taken    = 1'b1;
            end else if (op == abps_pkg::OP_RESET && seq_code == abps_pkg::MS_NORMAL) begin
                rst_line = 1'b1;
                seq_code = abps_pkg::MS_RESET_PRESS;
                taken    = 1'b1;
            end
            if (taken) begin
                press_count = '0;
            end
        end else begin
            // The power-level change is handled before the state step.
            if (pg != pg_seen) begin
                ev        = pg_seen ? abps_pkg::EV_OFF : abps_pkg::EV_ON;
                led_level = ~pg_seen;
                pg_seen   = pg;
            end
            if (press_count != abps_pkg::TICK_MAX) begin
                press_count = press_count + 16'd1;
            end
            case (seq_code)
                abps_pkg::MS_SHORT_POWER: begin
                    if (press_count >= short_len) begin
                        seq_code = abps_pkg::MS_WAIT_CHECK;
                        pwr_line = 1'b0;
                    end
                end
                abps_pkg::MS_LONG_POWER: begin
                    if (press_count >= long_len || !pg) begin
                        seq_code = abps_pkg::MS_WAIT_CHECK;
                        pwr_line = 1'b0;
                    end
                end
                abps_pkg::MS_RESET_PRESS: begin
                    if (press_count >= short_len) begin
                        seq_code = abps_pkg::MS_WAIT_CHECK;
                        rst_line = 1'b0;
                    end
                end
                default: begin
                    seq_code = pg ? abps_pkg::MS_NORMAL : abps_pkg::MS_DOWN;
                end
            endcase
        end
        r.power_switch_pressed = pwr_line;
        r.reset_switch_pressed = rst_line;
        r.power_event          = ev;
        r.led_on               = led_level;
        r.command_taken        = taken;
        r.machine_state        = seq_code;
        predicted.push_back(r);
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            failures++;
        end
    endfunction

    function void check_result(abps_pkg::result_t got);
        abps_pkg::result_t want;
        if (predicted.size() == 0) begin
            $error("result transaction with no prediction waiting");
            failures++;
            return;
        end
        want = predicted.pop_front();
        compare_field("power_switch_pressed", want.power_switch_pressed,
                      got.power_switch_pressed);
        compare_field("reset_switch_pressed", want.reset_switch_pressed,
                      got.reset_switch_pressed);
        compare_field("power_event", want.power_event, got.power_event);
        compare_field("led_on", want.led_on, got.led_on);
        compare_field("command_taken", want.command_taken, got.command_taken);
        compare_field("machine_state", want.machine_state, got.machine_state);
    endfunction

endclass

module tb_atx_power_button_sequencer;

    // Cycles without any accepted transaction before the run is declared hung.
    // The longest legitimate gap is the hold_results result stall plus the
    // pass through both pipeline registers and a configuration pause.
    localparam int unsigned HANG_LIMIT = 4000;

    logic                        aclk = 1'b0;
    logic                        aresetn;
    logic                        cfg_wr_en;
    logic                        cfg_addr;
    logic [abps_pkg::TICK_W-1:0] cfg_wdata;
    logic                        s_valid;
    logic                        s_ready;
    logic                        s_action;
    logic [1:0]                  s_command_op;
    logic                        s_power_good;
    logic                        m_valid;
    logic                        m_ready;
    logic                        m_power_switch_pressed;
    logic                        m_reset_switch_pressed;
    logic [1:0]                  m_power_event;
    logic                        m_led_on;
    logic                        m_command_taken;
    logic [2:0]                  m_machine_state;
    abps_pkg::result_t           m_result;

    button_press_scoreboard sb;

    // Set by the stimulus: quiet_run turns off all idling for the final
    // phase, and hold_results asks the result side for one long stall.
    logic        quiet_run    = 1'b0;
    logic        hold_results = 1'b0;
    int unsigned idle_edges;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    atx_power_button_sequencer u_dut (
        .aclk                   (aclk),
        .aresetn                (aresetn),
        .cfg_wr_en              (cfg_wr_en),
        .cfg_addr               (cfg_addr),
        .cfg_wdata              (cfg_wdata),
        .s_valid                (s_valid),
        .s_ready                (s_ready),
        .s_action               (s_action),
        .s_command_op           (s_command_op),
        .s_power_good           (s_power_good),
        .m_valid                (m_valid),
        .m_ready                (m_ready),
        .m_power_switch_pressed (m_power_switch_pressed),
        .m_reset_switch_pressed (m_reset_switch_pressed),
        .m_power_event          (m_power_event),
        .m_led_on               (m_led_on),
        .m_command_taken        (m_command_taken),
        .m_machine_state        (m_machine_state)
    );

    assign m_result = {m_power_switch_pressed, m_reset_switch_pressed, m_power_event,
                       m_led_on, m_command_taken, m_machine_state};

    // Both channels are observed at the rising edge, by which every input has
    // settled since the falling edge before it. An accepted input transaction
    // advances the predicted machine; an accepted result is checked against
    // the oldest prediction.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                sb.note_item(s_action, s_command_op, s_power_good);
            end
            if (m_valid && m_ready) begin
                sb.check_result(m_result);
            end
        end
    end

    // Hang detection: count edges at which neither channel moves a transaction.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_edges <= 0;
        end else begin
            idle_edges <= idle_edges + 1;
        end
    end

    initial begin : hang_watch
        wait (idle_edges >= HANG_LIMIT);
        $display("tb_atx_power_button_sequencer failed");
        $finish;
    end

    // Result side. It alternates ready stretches of random length with random
    // stalls, takes one long stall on request so that both pipeline stages fill
    // and s_ready drops, and stays ready once the run is quiet. Each iteration
    // makes exactly one assignment to m_ready at a falling edge.
    initial begin : result_sink
        int unsigned hold;
        m_ready = 1'b0;
        wait (aresetn);
        forever begin
            if (hold_results) begin
                hold_results = 1'b0;
                m_ready <= 1'b0;
                hold = 40;
            end else if (!quiet_run && $urandom_range(0, 4) == 0) begin
                m_ready <= 1'b0;
                hold = $urandom_range(1, 3);
            end else begin
                m_ready <= 1'b1;
                hold = quiet_run ? 1 : $urandom_range(1, 8);
            end
            repeat (hold) @(negedge aclk);
        end
    end

    // Offers one transaction and returns at the falling edge after it was
    // accepted. A random idle burst may come first; valid is otherwise left
    // high so that back-to-back transactions need no extra edge.
    task automatic send_item(input logic act, input logic [1:0] op, input logic pg);
        int unsigned gap;
        if (!quiet_run && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            gap = $urandom_range(1, 3);
            repeat (gap) @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_action     <= act;
        s_command_op <= op;
        s_power_good <= pg;
        do begin
            @(posedge aclk);
        end while (!(s_valid && s_ready));
        @(negedge aclk);
    endtask

    // Picks the next transaction from the predicted machine state, so that
    // most of the traffic walks real press sequences: power-on from down,
    // power rising during the press, then power-off or reset from normal.
    // About one in ten transactions is unconstrained noise.
    task automatic send_shaped_item();
        int unsigned roll;
        logic        act;
        logic [1:0]  op;
        logic        pg;
        roll = $urandom_range(0, 99);
        act  = abps_pkg::ACT_TICK;
        op   = 2'($urandom);
        pg   = sb.pg_seen;
        if (roll < 10) begin
            act = 1'($urandom);
            pg  = 1'($urandom);
        end else begin
            case (sb.seq_code)
                abps_pkg::MS_DOWN: begin
                    if (roll < 40) begin
                        act = abps_pkg::ACT_COMMAND;
                        op  = (roll < 32) ? abps_pkg::OP_ON : 2'($urandom);
                    end
                end
                abps_pkg::MS_NORMAL: begin
                    if (roll < 45) begin
                        act = abps_pkg::ACT_COMMAND;
                        op  = (roll < 25) ? abps_pkg::OP_OFF :
                              (roll < 40) ? abps_pkg::OP_RESET : 2'($urandom);
                    end else if ($urandom_range(0, 9) == 0) begin
                        pg = 1'b0;
                    end
                end
                abps_pkg::MS_SHORT_POWER: begin
                    if ($urandom_range(0, 2) == 0) begin
                        pg = 1'b1;
                    end
                end
                abps_pkg::MS_LONG_POWER: begin
                    if ($urandom_range(0, 3) == 0) begin
                        pg = 1'b0;
                    end
                end
                default: begin
                    if ($urandom_range(0, 4) == 0) begin
                        pg = ~sb.pg_seen;
                    end
                end
            endcase
        end
        send_item(act, op, pg);
    endtask

    // Stops offering input and waits until every predicted result has been
    // accepted. Each transaction yields one result, so nothing is left in
    // flight afterward; the trailing wait only separates phases.
    task automatic wait_for_results();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge aclk);
        repeat (3) @(negedge aclk);
    endtask

    // Writes one register; only called with the block idle.
    task automatic program_reg(input logic idx, input logic [abps_pkg::TICK_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        sb.write_reg(idx, val);
        @(negedge aclk);
    endtask

    initial begin : stimulus
        int                          phase;
        logic [abps_pkg::TICK_W-1:0] short_v;
        logic [abps_pkg::TICK_W-1:0] long_v;

        sb = new();
        sb.clear();
        aresetn      = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_addr     = abps_pkg::CFG_SHORT_PRESS;
        cfg_wdata    = '0;
        s_valid      = 1'b0;
        s_action     = abps_pkg::ACT_TICK;
        s_command_op = abps_pkg::OP_NOP;
        s_power_good = 1'b0;

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part, starting from the reset press lengths.
        // Idle tick, then commands that the down state must ignore.
        send_item(abps_pkg::ACT_TICK, abps_pkg::OP_NOP, 1'b0);
        send_item(abps_pkg::ACT_COMMAND, abps_pkg::OP_NOP, 1'b1);
        send_item(abps_pkg::ACT_COMMAND, abps_pkg::OP_OFF, 1'b0);
        send_item(abps_pkg::ACT_COMMAND, abps_pkg::OP_RESET, 1'b1);
        // Power-on is taken; a second one during the press is not.
        send_item(abps_pkg::ACT_COMMAND, abps_pkg::OP_ON, 1'b0);
        send_item(abps_pkg::ACT_COMMAND, abps_pkg::OP_ON, 1'b0);
        // Still pressed under the default short length; power comes up on
        // the last tick, which raises the powered-on event mid-press.
        repeat (3) send_item(abps_pkg::ACT_TICK, abps_pkg::OP_NOP, 1'b0);
        send_item(abps_pkg::ACT_TICK, abps_pkg::OP_ON, 1'b1);

        // A zero short length releases a press on the very next tick.
        wait_for_results();
        program_reg(abps_pkg::CFG_SHORT_PRESS, 16'd0);
        send_item(abps_pkg::ACT_TICK, abps_pkg::OP_RESET, 1'b1);
        send_item(abps_pkg::ACT_TICK, abps_pkg::OP_NOP, 1'b1);
        send_item(abps_pkg::ACT_COMMAND, abps_pkg::OP_RESET, 1'b0);
        send_item(abps_pkg::ACT_TICK, abps_pkg::OP_NOP, 1'b1);
        send_item(abps_pkg::ACT_TICK, abps_pkg::OP_NOP, 1'b1);

        // Forced power-off under the default long length: it is cut short
        // when power drops, together with the powered-off event.
        send_item(abps_pkg::ACT_COMMAND, abps_pkg::OP_OFF, 1'b0);
        send_item(abps_pkg::ACT_COMMAND, abps_pkg::OP_RESET, 1'b0);
        send_item(abps_pkg::ACT_TICK, abps_pkg::OP_NOP, 1'b1);
        send_item(abps_pkg::ACT_TICK, abps_pkg::OP_NOP, 1'b0);
        send_item(abps_pkg::ACT_TICK, abps_pkg::OP_NOP, 1'b0);
        // Power changes seen directly from the idle states.
        send_item(abps_pkg::ACT_TICK, abps_pkg::OP_NOP, 1'b1);
        send_item(abps_pkg::ACT_TICK, abps_pkg::OP_NOP, 1'b0);

        // Random part in phases. Each phase starts from an idle block with new
        // press lengths; a press left open by one phase may end early under
        // the next phase's shorter length.
        for (phase = 0; phase < 8; phase++) begin
            wait_for_results();
            case (phase)
                0: begin
                    short_v = 16'd1;
                    long_v  = 16'd1;
                end
                1: begin
                    short_v = 16'd2;
                    long_v  = abps_pkg::TICK_MAX;
                end
                2: begin
                    short_v = abps_pkg::TICK_MAX;
                    long_v  = 16'd3;
                end
                3: begin
                    short_v = 16'($urandom_range(1, 300));
                    long_v  = 16'($urandom_range(1, 300));
                end
                default: begin
                    short_v = 16'($urandom_range(1, 6));
                    long_v  = 16'($urandom_range(1, 12));
                end
            endcase
            program_reg(abps_pkg::CFG_SHORT_PRESS, short_v);
            program_reg(abps_pkg::CFG_LONG_PRESS, long_v);
            if (phase == 4) begin
                hold_results = 1'b1;
            end
            if (phase == 7) begin
                quiet_run = 1'b1;
            end
            repeat (118) send_shaped_item();
        end

        wait_for_results();
        repeat (10) @(posedge aclk);
        if (sb.failures == 0 && sb.pending() == 0) begin
            $display("tb_atx_power_button_sequencer passed");
        end else begin
            $display("tb_atx_power_button_sequencer failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/abps_pkg.sv
hw/rtl/abps_core.sv
hw/rtl/atx_power_button_sequencer.sv
hw/rtl/abps_checker.sv
sim/tb_atx_power_button_sequencer.sv
